// ===== rtl/b2da_pkg.sv =====
// Package for the binary to decimal ASCII unit: constants, controller state and control structs.
package b2da_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // Decimal digits of 2**w - 1 is floor(w * log10(2)) + 1; log10(2) ~ 1233 / 4096.
    localparam int LOG10_2_NUM   = 1233;
    localparam int LOG10_2_SHIFT = 12;

    localparam int CHAR_W      = 6;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // Double-dabble correction: a BCD digit of five or more gets three added before the shift.
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic ready;    // input can be taken
        logic load;     // capture a new value, clear BCD
        logic shift;    // one adjust-and-shift step
        logic dec_idx;  // step digit pointer toward the LSD
        logic emit;     // load output register with the current digit
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic digit_zero;
        logic idx_zero;
        logic out_free;
    } status_t;

    function automatic int digits_for_width(input int w);
        int d;
        begin
            d = ((w * LOG10_2_NUM) >> LOG10_2_SHIFT) + 1;
            return d;
        end
    endfunction

endpackage

// ===== rtl/b2da_ctrl.sv =====
// Controller state machine of the binary to decimal ASCII unit.
module b2da_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  b2da_pkg::status_t status,
    output b2da_pkg::cmd_t    cmd
);

    b2da_pkg::state_t state_reg;
    b2da_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= b2da_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            b2da_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = b2da_pkg::ST_CONV;
                end
            end
            b2da_pkg::ST_CONV:
            begin
                if (status.conv_done)
                begin
                    state_next = b2da_pkg::ST_SKIP;
                end
            end
            b2da_pkg::ST_SKIP:
            begin
                if (!status.digit_zero || status.idx_zero)
                begin
                    state_next = b2da_pkg::ST_EMIT;
                end
            end
            b2da_pkg::ST_EMIT:
            begin
                if (status.out_free && status.idx_zero)
                begin
                    state_next = b2da_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = b2da_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            b2da_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.load  = in_valid;
            end
            b2da_pkg::ST_CONV:
            begin
                cmd.shift = !status.conv_done;
            end
            b2da_pkg::ST_SKIP:
            begin
                cmd.dec_idx = status.digit_zero && !status.idx_zero;
            end
            b2da_pkg::ST_EMIT:
            begin
                cmd.emit    = status.out_free;
                cmd.dec_idx = status.out_free && !status.idx_zero;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/b2da_datapath.sv =====
// Datapath of the binary to decimal ASCII unit: double-dabble registers and output register.
module b2da_datapath #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  b2da_pkg::cmd_t               cmd,
    input  logic [VALUE_WIDTH-1:0]       value,
    input  logic                         out_ready,
    output b2da_pkg::status_t            status,
    output logic                         out_valid,
    output logic [b2da_pkg::CHAR_W-1:0]  out_char,
    output logic                         out_last
);

    localparam int NUM_DIGITS = b2da_pkg::digits_for_width(VALUE_WIDTH);
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W      = $clog2(NUM_DIGITS);

    logic [VALUE_WIDTH-1:0]      bin_reg;
    logic [BCD_W-1:0]            bcd_reg;
    logic [BCD_W-1:0]            bcd_adj;
    logic [CNT_W-1:0]            cnt_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [3:0]                  cur_digit;
    logic                        out_valid_reg;
    logic [b2da_pkg::CHAR_W-1:0] out_char_reg;
    logic                        out_last_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= b2da_pkg::BCD_ADJ_MIN)
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + b2da_pkg::BCD_ADJ_ADD;
            end
            else
            begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
            cnt_reg <= CNT_W'(VALUE_WIDTH);
        end
        else if (cmd.shift)
        begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_reg <= {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= IDX_W'(NUM_DIGITS - 1);
        end
        else if (cmd.dec_idx)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= b2da_pkg::ASCII_ZERO + {2'b00, cur_digit};
            out_last_reg <= (idx_reg == '0);
        end
    end

    assign status.conv_done  = (cnt_reg == '0);
    assign status.digit_zero = (cur_digit == 4'd0);
    assign status.idx_zero   = (idx_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
// Binary to decimal ASCII unit: top level joining controller and datapath.
// Sequence: after the accept, the serial shift-and-adjust loop runs, then leading zeros are skipped
//   (up to NUM_DIGITS-1 of them) before the first digit is emitted.
// Throughput: one value at a time; a new value is taken only once the last digit of the
//   previous one has been emitted. Leading zeros are skipped at one per cycle, and digits are
//   emitted at one per cycle while the output is not stalled.
// Reset: rst_n asynchronous active low; clears the controller to idle and the output valid.
module binary_to_decimal_ascii_unit #(
    parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream: one binary value per item
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,   // [VALUE_WIDTH-1:0] value
    // output stream: one ASCII digit per item, MSD first
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [b2da_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [5:0] digit_char, rest zero
    output logic                                m_axis_tlast    // last_digit
);

    b2da_pkg::cmd_t              cmd;
    b2da_pkg::status_t           status;
    logic [b2da_pkg::CHAR_W-1:0] digit_char;

    // Sequencer: idle -> convert -> skip leading zeros -> emit digits.
    b2da_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    // Shift register, BCD digits, digit pointer and output register.
    b2da_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (s_axis_tdata[VALUE_WIDTH-1:0]),
        .out_ready (m_axis_tready),
        .status    (status),
        .out_valid (m_axis_tvalid),
        .out_char  (digit_char),
        .out_last  (m_axis_tlast)
    );

    assign s_axis_tready = cmd.ready;
    // pad the 6-bit code to a full byte
    assign m_axis_tdata  = {(b2da_pkg::OUT_TDATA_W - b2da_pkg::CHAR_W)'(0), digit_char};

endmodule

// ===== verif/tb.sv =====
// Testbench for binary_to_decimal_ascii_unit: ASCII digit streams checked against a predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = 32;
    localparam int IN_TDATA_W  = ((VW + 7) / 8) * 8;
    localparam int MAX_DIGITS  = 10;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;
    // Drain pause at the end: well over one full conversion.
    localparam int TAIL_CYCLES = 2 * (VW + 2 * MAX_DIGITS + 2);

    // One expected output item: digit code plus end-of-number flag.
    typedef struct packed {
        logic [b2da_pkg::CHAR_W-1:0] digit_char;
        logic                        last_digit;
    } digit_item_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [IN_TDATA_W-1:0]             s_axis_tdata;   // [31:0] value
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [b2da_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;   // [5:0] digit_char, [7:6] zero
    logic                              m_axis_tlast;   // last_digit

    // Digits still owed by the DUT, oldest first.
    digit_item_t pending_digits[$];

    int  mismatches   = 0;
    int  cycle_count  = 0;
    bit  tx_idle_on   = 1'b0;   // sender draws random gaps
    bit  rx_idle_on   = 1'b0;   // receiver draws random stalls
    int  rx_holdoff   = 0;      // one-off long receiver stall, picked up by the receiver

    binary_to_decimal_ascii_unit #(.VALUE_WIDTH(VW)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Run limit; a hang anywhere ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digits outstanding",
                     cycle_count, pending_digits.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Split a value into decimal digits and queue them MSD first.
    // Zero still gives one digit; the last one carries the flag.
    task automatic queue_decimal_digits(input logic [VW-1:0] value);
        logic [3:0]  digs[MAX_DIGITS];
        logic [VW-1:0] rest;
        digit_item_t item;
        int          n;
        begin
            rest = value;
            n    = 0;
            do
            begin
                digs[n] = 4'(rest % 10);
                rest    = rest / 10;
                n++;
            end
            while (rest != 0);
            for (int k = n - 1; k >= 0; k--)
            begin
                item.digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(digs[k]);
                item.last_digit = (k == 0);
                pending_digits.push_back(item);
            end
        end
    endtask

    task automatic note_mismatch(input string what);
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Output checker: every accepted digit against the oldest expectation.
    // Padding bits above digit_char are expected zero.
    always @(posedge clk)
    begin
        digit_item_t exp_item;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_digits.size() == 0)
                note_mismatch($sformatf("unexpected digit tdata=%02h tlast=%b",
                                        m_axis_tdata, m_axis_tlast));
            else
            begin
                exp_item = pending_digits.pop_front();
                if (m_axis_tdata !== b2da_pkg::OUT_TDATA_W'(exp_item.digit_char))
                    note_mismatch($sformatf("digit_char exp %02h got %02h",
                                            exp_item.digit_char, m_axis_tdata));
                if (m_axis_tlast !== exp_item.last_digit)
                    note_mismatch($sformatf("last_digit exp %b got %b (char %02h)",
                                            exp_item.last_digit, m_axis_tlast,
                                            exp_item.digit_char));
            end
        end
    end

    // Receiver: random stall before each digit, or a long one-off hold-off.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            stall = rx_idle_on ? $urandom_range(0, 9) : 0;
            if (rx_holdoff > 0)
            begin
                stall      = rx_holdoff;
                rx_holdoff = 0;
            end
            if (stall > 0)
            begin
                @(negedge clk) m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(rst_n && m_axis_tvalid));
        end
    end

    // Offer one value; predict its digits on the accepting edge.
    // tvalid stays high afterwards so back-to-back items need no bubble.
    task automatic send_value(input logic [VW-1:0] value);
        int gap;
        begin
            gap = tx_idle_on ? $urandom_range(0, 9) : 0;
            repeat (gap) @(negedge clk) s_axis_tvalid <= 1'b0;
            @(negedge clk);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= IN_TDATA_W'(value);
            do @(posedge clk); while (!s_axis_tready);
            queue_decimal_digits(value);
        end
    endtask

    task automatic sender_quiet();
        begin
            @(negedge clk) s_axis_tvalid <= 1'b0;
        end
    endtask

    // Sender off until every owed digit has come out.
    task automatic wait_drained();
        begin
            sender_quiet();
            while (pending_digits.size() != 0) @(posedge clk);
        end
    endtask

    // Extremes, every digit value, digit-count boundaries.
    task automatic test_directed();
        logic [VW-1:0] corner[$];
        begin
            corner = {32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100,
                      32'd1234567890, 32'd987654321, 32'd999999999, 32'd1000000000,
                      32'd4294967295, 32'd4294967294, 32'd2147483647, 32'd2147483648,
                      32'hAAAAAAAA, 32'h55555555, 32'd100000, 32'd10000000,
                      32'd4000000000, 32'd0};
            foreach (corner[i])
                send_value(corner[i]);
            wait_drained();
        end
    endtask

    // Random values in stretches with and without idling on each side.
    task automatic test_random_values(input int count);
        logic [VW-1:0] value;
        logic [63:0]   pow10;
        int            bits;
        begin
            for (int i = 0; i < count; i++)
            begin
                if (i % 40 == 0)
                begin
                    tx_idle_on = ($urandom_range(0, 3) != 0);
                    rx_idle_on = ($urandom_range(0, 3) != 0);
                end
                case ($urandom_range(0, 3))
                    0:
                        value = $urandom;
                    1, 2:
                    begin
                        // varied magnitude so every digit count shows up
                        bits  = $urandom_range(1, VW);
                        value = $urandom;
                        if (bits < VW)
                            value = value & ((32'd1 << bits) - 32'd1);
                    end
                    default:
                    begin
                        // around a power of ten: 99..9, 10..0, 10..01
                        pow10 = 64'd1;
                        repeat ($urandom_range(0, 9)) pow10 = pow10 * 64'd10;
                        value = VW'(pow10 + 64'($urandom_range(0, 2)) - 64'd1);
                    end
                endcase
                send_value(value);
            end
            wait_drained();
        end
    endtask

    // Receiver holds off a long time while the sender keeps offering items.
    task automatic test_output_holdoff();
        begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
            rx_holdoff = 300;
            repeat (8) send_value($urandom);
            wait_drained();
        end
    endtask

    // Both sides at full rate.
    task automatic test_back_to_back(input int count);
        begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
            repeat (count) send_value($urandom);
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_directed();
        test_random_values(300);
        test_output_holdoff();
        test_back_to_back(32);

        // let any straggler show up as an unexpected digit
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_digits.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/b2da_pkg.sv
rtl/b2da_ctrl.sv
rtl/b2da_datapath.sv
rtl/binary_to_decimal_ascii_unit.sv
verif/tb.sv
